@@ sv/pim_assert_state_machine_assert.svh @@
// assertion macros for the pim assert state machine
// used by the controller and the top level
`ifndef PIM_ASSERT_STATE_MACHINE_ASSERT_SVH
`define PIM_ASSERT_STATE_MACHINE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define PAS_ASSERT_IMP(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// implication checked in the next cycle
`define PAS_ASSERT_NXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

@@ sv/pas_pkg.sv @@
// types and constants shared by the pim assert state machine
// no dependencies
package pas_pkg;
  localparam logic [1:0] MODE_ASSERT = 2'd0;
  localparam logic [1:0] MODE_WRONGIF = 2'd1;
  localparam logic [1:0] MODE_COULD = 2'd2;
  localparam logic [1:0] MODE_TIMER = 2'd3;

  localparam logic [1:0] ST_NOINFO = 2'd0;
  localparam logic [1:0] ST_WINNER = 2'd1;
  localparam logic [1:0] ST_LOSER = 2'd2;

  localparam logic [2:0] REG_SG = 3'd0;
  localparam logic [2:0] REG_PREF_S = 3'd1;
  localparam logic [2:0] REG_COST_S = 3'd2;
  localparam logic [2:0] REG_PREF_RP = 3'd3;
  localparam logic [2:0] REG_COST_RP = 3'd4;
  localparam logic [2:0] REG_HOLD = 3'd5;
  localparam logic [2:0] REG_OVR = 3'd6;
  localparam logic [2:0] REG_RPF = 3'd7;

  typedef struct packed {
    logic [31:0] rp;
    logic [31:0] cost;
    logic [31:0] addr;
  } metric_t;

  // controller to datapath
  typedef struct packed {
    logic rd;   // launch the read of the interface entry
    logic wr;   // compute and write back, capture result
  } cmd_t;

  function automatic logic better(metric_t a, metric_t b);
    if (a.rp != b.rp) return a.rp < b.rp;
    if (a.cost != b.cost) return a.cost < b.cost;
    return a.addr > b.addr;
  endfunction
endpackage

@@ sv/pim_assert_state_machine.sv @@
// top level of the pim assert state machine
// depends on pas_pkg, pas_ctrl, pas_dp and the assertion header
//
// usage: one event item enters on in_valid/in_ready (mode, if_index, own
// address, received assert metric, CouldAssert, tracking desired)
// first, in idle: item accepted, per-interface entry read into registers
// then, in calc: metric compare, state update written back, result registered
// the result item then sits on out_valid until out_ready takes it
// one item is in flight at a time, set by the read-modify-write of the
// interface entry; no new item is accepted before the result is taken
// a stalled receiver holds the result and in_ready stays low
// configuration: cfg_we, cfg_index, cfg_data, written while idle
// reset clears all interface states to NoInfo, latches and flags to zero,
// winner metrics to infinite (through valid bits) and registers to defaults
// no clearing pass is needed
`include "pim_assert_state_machine_assert.svh"
module pim_assert_state_machine #(
  parameter int NUM_IFS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] mode,
  input  logic [4:0] if_index,
  input  logic [31:0] my_addr,
  input  logic peer_rpt_bit,
  input  logic [30:0] peer_pref,
  input  logic [31:0] peer_cost,
  input  logic [31:0] peer_addr,
  input  logic could_assert,
  input  logic tracking_desired,
  output logic out_valid,
  input  logic out_ready,
  output logic status,
  output logic [1:0] new_state,
  output logic send_assert,
  output logic send_cancel,
  output logic timer_start,
  output logic [15:0] timer_value,
  output logic spt_bit,
  output logic winner_beats_spt,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import pas_pkg::*;

  // configuration registers
  logic sg;
  logic [30:0] pref_s, pref_rp;
  logic [31:0] cost_s, cost_rp;
  logic [15:0] hold, ovr;
  logic [4:0] rpf;
  cmd_t cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      sg <= 1'b1; pref_s <= '0; cost_s <= '0; pref_rp <= '0; cost_rp <= '0;
      hold <= 16'd180; ovr <= 16'd3; rpf <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SG: sg <= cfg_data[0];
        REG_PREF_S: pref_s <= cfg_data[30:0];
        REG_COST_S: cost_s <= cfg_data;
        REG_PREF_RP: pref_rp <= cfg_data[30:0];
        REG_COST_RP: cost_rp <= cfg_data;
        REG_HOLD: hold <= cfg_data[15:0];
        REG_OVR: ovr <= cfg_data[15:0];
        REG_RPF: rpf <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  pas_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
  );

  pas_dp #(.NUM_IFS(NUM_IFS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .mode(mode), .if_index(if_index),
    .my_addr(my_addr), .peer_rpt_bit(peer_rpt_bit), .peer_pref(peer_pref),
    .peer_cost(peer_cost), .peer_addr(peer_addr), .could_assert(could_assert),
    .tracking_desired(tracking_desired), .cfg_sg(sg), .cfg_pref_s(pref_s),
    .cfg_cost_s(cost_s), .cfg_pref_rp(pref_rp), .cfg_cost_rp(cost_rp),
    .cfg_hold(hold), .cfg_ovr(ovr), .cfg_rpf(rpf), .status(status),
    .new_state(new_state), .send_assert(send_assert), .send_cancel(send_cancel),
    .timer_start(timer_start), .timer_value(timer_value), .spt_bit(spt_bit),
    .winner_beats_spt(winner_beats_spt)
  );

  // a timer reload is only reported together with a restart
  `PAS_ASSERT_IMP(a_tval, out_valid && !timer_start, timer_value == 16'd0, "stray reload")
  // once set, the spt bit stays set
  `PAS_ASSERT_NXT(a_spt, out_valid && spt_bit && out_ready, $stable(spt_bit) || !out_valid, "spt bit fell")
  // assert and cancel never requested together
  `PAS_ASSERT_IMP(a_msg, out_valid, !(send_assert && send_cancel), "assert and cancel together")
endmodule

@@ sv/pas_ctrl.sv @@
// controller of the pim assert state machine: accept, read, write, deliver
// depends on pas_pkg and the assertion header
`include "pim_assert_state_machine_assert.svh"
module pas_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output pas_pkg::cmd_t cmd
);
  import pas_pkg::*;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_OUT = 2'd2;
  logic [1:0] state, state_next;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign cmd.rd = in_valid && in_ready;
  assign cmd.wr = (state == S_CALC);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_CALC;
      S_CALC: state_next = S_OUT;
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  `PAS_ASSERT_NXT(a_rd_calc, cmd.rd, cmd.wr, "read not followed by compute")
  `PAS_ASSERT_NXT(a_calc_out, cmd.wr, out_valid, "compute not followed by result")
  `PAS_ASSERT_IMP(a_excl, out_valid, !in_ready, "accepting while a result waits")
endmodule

@@ sv/pas_dp.sv @@
// datapath: per-interface storage, metric compare and result register
// depends on pas_pkg
module pas_dp #(
  parameter int NUM_IFS = 32
) (
  input  logic clk,
  input  logic rst,
  input  pas_pkg::cmd_t cmd,
  input  logic [1:0] mode,
  input  logic [4:0] if_index,
  input  logic [31:0] my_addr,
  input  logic peer_rpt_bit,
  input  logic [30:0] peer_pref,
  input  logic [31:0] peer_cost,
  input  logic [31:0] peer_addr,
  input  logic could_assert,
  input  logic tracking_desired,
  input  logic cfg_sg,
  input  logic [30:0] cfg_pref_s,
  input  logic [31:0] cfg_cost_s,
  input  logic [30:0] cfg_pref_rp,
  input  logic [31:0] cfg_cost_rp,
  input  logic [15:0] cfg_hold,
  input  logic [15:0] cfg_ovr,
  input  logic [4:0] cfg_rpf,
  output logic status,
  output logic [1:0] new_state,
  output logic send_assert,
  output logic send_cancel,
  output logic timer_start,
  output logic [15:0] timer_value,
  output logic spt_bit,
  output logic winner_beats_spt
);
  import pas_pkg::*;
  localparam int IW = (NUM_IFS > 1) ? $clog2(NUM_IFS) : 1;

  // small per-interface state in flip-flops (cleared at reset)
  logic [1:0] ifst [NUM_IFS];
  logic ca_latch [NUM_IFS];
  logic wbf [NUM_IFS];
  logic [NUM_IFS-1:0] wvalid;
  logic spt_flag;
  // winner metric memory; invalid entries read as infinite
  metric_t wmem [NUM_IFS];

  // item registers
  logic [1:0] r_mode;
  logic [31:0] r_me;
  metric_t r_peer;
  logic r_ca, r_td, r_inr;
  logic [IW-1:0] r_idx;
  logic [1:0] r_cur;
  logic r_cal, r_wbf, r_wv;
  metric_t r_w;

  logic in_range;
  logic [IW-1:0] idx;
  assign in_range = ({3'd0, if_index} < 8'(NUM_IFS)) || (NUM_IFS > 32);
  assign idx = IW'(if_index);

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      r_mode <= mode; r_me <= my_addr;
      r_peer <= '{rp: {peer_rpt_bit, peer_pref}, cost: peer_cost, addr: peer_addr};
      r_ca <= could_assert; r_td <= tracking_desired;
      r_inr <= in_range; r_idx <= idx;
      r_cur <= ifst[idx]; r_cal <= ca_latch[idx]; r_wbf <= wbf[idx];
      r_wv <= wvalid[idx];
      r_w <= wmem[idx];
    end
  end

  metric_t spt_m, rpt_m, own_claim, mine, wm;
  logic sg, win, prpt;
  logic [2:0] act;
  logic st_o, sn_o, cn_o, ts_o;
  logic [15:0] tv_o, wtime;
  logic [1:0] ns;
  logic nb, do_store, do_del, set_spt, ca_wr;
  metric_t store_m;

  always_comb begin
    sg = cfg_sg;
    spt_m = '{rp: {1'b0, cfg_pref_s}, cost: cfg_cost_s, addr: r_me};
    rpt_m = '{rp: {1'b1, cfg_pref_rp}, cost: cfg_cost_rp, addr: r_me};
    own_claim = sg ? spt_m : rpt_m;
    mine = (sg && spt_flag) ? spt_m : rpt_m;
    win = better(mine, r_peer);
    prpt = r_peer.rp[31];
    wm = r_wv ? r_w : '{rp: '1, cost: '1, addr: '0};
    wtime = (cfg_hold > cfg_ovr) ? cfg_hold - cfg_ovr : 16'd0;
    act = 3'd0; st_o = 1'b1; sn_o = 1'b0; cn_o = 1'b0; ts_o = 1'b0; tv_o = 16'd0;
    ns = r_cur; nb = r_wbf; do_store = 1'b0; do_del = 1'b0; set_spt = 1'b0;
    ca_wr = 1'b0; store_m = own_claim;
    unique case (r_mode)
      MODE_ASSERT: begin
        if (r_cur == ST_NOINFO) begin
          if (sg) begin
            if (win && !prpt && r_ca) act = 3'd1;
            else if (prpt && r_ca) act = 3'd1;
            else if (!win && !prpt && r_td) act = 3'd6;
          end else begin
            if (win && prpt && r_ca) act = 3'd1;
            else if (!win && prpt && r_td) act = 3'd2;
          end
        end else if (r_cur == ST_WINNER) act = win ? 3'd3 : 3'd2;
        else if (!win) act = 3'd2;
        else if (wm.addr == r_peer.addr) act = 3'd5;
      end
      MODE_WRONGIF: begin
        st_o = 1'b0;
        if (r_cur == ST_NOINFO && r_ca) act = 3'd1;
      end
      MODE_COULD: begin
        if (r_ca != r_cal) begin
          ca_wr = 1'b1; st_o = 1'b0;
          if (r_cur == ST_WINNER && !r_ca) begin
            cn_o = 1'b1; do_del = 1'b1; ns = ST_NOINFO;
          end
        end
      end
      MODE_TIMER: begin
        if (r_cur == ST_WINNER) act = 3'd3;
        else if (r_cur == ST_LOSER) act = 3'd5;
      end
      default: ;
    endcase
    if (act != 3'd0) st_o = 1'b0;
    case (act)
      3'd1: begin
        sn_o = 1'b1; ts_o = 1'b1; tv_o = wtime; do_store = 1'b1; ns = ST_WINNER;
      end
      3'd3: begin
        sn_o = 1'b1; ts_o = 1'b1; tv_o = wtime; ns = ST_WINNER;
      end
      3'd2, 3'd6: begin
        ts_o = 1'b1; tv_o = cfg_hold; do_store = 1'b1; store_m = r_peer;
        ns = ST_LOSER;
        if (act == 3'd6 && 32'(r_idx) == 32'(cfg_rpf)) set_spt = 1'b1;
      end
      3'd5: begin
        do_del = 1'b1; ns = ST_NOINFO;
      end
      default: ;
    endcase
    if (sg && do_store) nb = better(store_m, spt_m);
    if (sg && do_del) nb = 1'b0;
    if (!r_inr) begin
      st_o = 1'b1; sn_o = 1'b0; cn_o = 1'b0; ts_o = 1'b0; tv_o = 16'd0;
      do_store = 1'b0; do_del = 1'b0; set_spt = 1'b0; ca_wr = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_IFS; k++) begin
        ifst[k] <= ST_NOINFO; ca_latch[k] <= 1'b0; wbf[k] <= 1'b0;
      end
      wvalid <= '0;
      spt_flag <= 1'b0;
    end else if (cmd.wr && r_inr) begin
      ifst[r_idx] <= ns;
      wbf[r_idx] <= nb;
      if (ca_wr) ca_latch[r_idx] <= r_ca;
      if (set_spt) spt_flag <= 1'b1;
      if (do_store) wvalid[r_idx] <= 1'b1;
      if (do_del) wvalid[r_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && r_inr && do_store) wmem[r_idx] <= store_m;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      status <= st_o;
      new_state <= r_inr ? ns : ST_NOINFO;
      send_assert <= sn_o; send_cancel <= cn_o;
      timer_start <= ts_o; timer_value <= tv_o;
      spt_bit <= spt_flag | set_spt;
      winner_beats_spt <= r_inr ? nb : 1'b0;
    end
  end
endmodule
